FILE: design/ftr_pkg.sv
// ----------------------------------------------------------------------------
// ftr_pkg
// Types and constants shared by the fat-tree path routing block.
// ----------------------------------------------------------------------------
package ftr_pkg;

   localparam logic [2:0] KIND_SAME_LEAF = 3'd0;
   localparam logic [2:0] KIND_SAME_POD  = 3'd1;
   localparam logic [2:0] KIND_CROSS_POD = 3'd2;
   localparam logic [2:0] KIND_EQUAL     = 3'd3;
   localparam logic [2:0] KIND_RANGE     = 3'd4;

   localparam logic [1:0] CSR_SERVERS_PER_LEAF = 2'd0;
   localparam logic [1:0] CSR_LEAVES_PER_POD   = 2'd1;
   localparam logic [1:0] CSR_CORES_PER_SPINE  = 2'd2;
   localparam logic [1:0] CSR_POD_COUNT        = 2'd3;

   localparam logic [6:0] DEG_RESET = 7'd4;
   localparam logic [6:0] DEG_MAX   = 7'd64;

   typedef struct packed {
      logic [17:0] source_server;
      logic [17:0] dest_server;
      logic [15:0] group_id;
   } ftr_req_type;

   typedef struct packed {
      logic [2:0]  path_kind;
      logic [19:0] hop_edge_0;
      logic [19:0] hop_edge_1;
      logic [19:0] hop_edge_2;
      logic [19:0] hop_edge_3;
      logic [19:0] hop_edge_4;
      logic [19:0] hop_edge_5;
      logic [19:0] hop_node_0;
      logic [19:0] hop_node_1;
      logic [19:0] hop_node_2;
      logic [19:0] hop_node_3;
      logic [19:0] hop_node_4;
   } ftr_rsp_type;

   // clamped degrees and the sizes derived from them
   typedef struct packed {
      logic [6:0]  s;
      logic [6:0]  l;
      logic [6:0]  c;
      logic [12:0] spp;
      logic [12:0] ll;
      logic [12:0] lc;
      logic [18:0] n_srv;
      logic [19:0] esc_base;
      logic [19:0] spine_base;
      logic [19:0] core_base;
   } ftr_cfg_type;

   function automatic logic [6:0] clamp_deg(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (v == 7'd0) begin
         r = 7'd1;
      end else if (v > DEG_MAX) begin
         r = DEG_MAX;
      end
      return r;
   endfunction

endpackage

FILE: design/ftr_div_step.sv
// ----------------------------------------------------------------------------
// ftr_div_step
// STEPS restoring division steps: quotient bits FIRST down to FIRST-STEPS+1.
// ----------------------------------------------------------------------------
module ftr_div_step #(
   parameter int REM_W = 18,
   parameter int DEN_W = 13,
   parameter int Q_W   = 6,
   parameter int FIRST = 5,
   parameter int STEPS = 3
) (
   input  logic [REM_W-1:0] rem_i,
   input  logic [DEN_W-1:0] den_i,
   input  logic [Q_W-1:0]   q_i,
   output logic [REM_W-1:0] rem_o,
   output logic [Q_W-1:0]   q_o
);
   localparam int W = (REM_W > DEN_W + Q_W) ? REM_W + 1 : DEN_W + Q_W + 1;

   always_comb begin
      logic [W-1:0] r;
      logic [W-1:0] t;
      r   = W'(rem_i);
      q_o = q_i;
      for (int i = 0; i < STEPS; i++) begin
         t = W'(den_i) << (FIRST - i);
         if (r >= t) begin
            r = r - t;
            q_o[FIRST-i] = 1'b1;
         end
      end
      rem_o = r[REM_W-1:0];
   end
endmodule

FILE: design/ftr_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// ftr_pipe_ctrl
// Valid bits and per-stage load enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module ftr_pipe_ctrl #(
   parameter int STAGES = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  logic              out_stall,
   output logic [STAGES-1:0] load,
   output logic [STAGES-1:0] valid
);
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || !out_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_stall = !load[0];
   assign valid    = valid_ff;
endmodule

FILE: design/ftr_cfg.sv
// ----------------------------------------------------------------------------
// ftr_cfg
// Degree registers and the registered id bases derived from them.
// ----------------------------------------------------------------------------
module ftr_cfg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [6:0]           csr_data,
   output ftr_pkg::ftr_cfg_type cfg
);
   import ftr_pkg::*;

   logic [6:0]  s_ff, l_ff, c_ff, p_ff;
   logic [6:0]  s, l, c, p;
   logic [12:0] spp_ff, ll_ff, lc_ff, pl_ff;
   logic [18:0] n_srv_ff, pll_ff;
   logic [19:0] esc_ff, spine_ff, core_ff;

   assign s = clamp_deg(s_ff);
   assign l = clamp_deg(l_ff);
   assign c = clamp_deg(c_ff);
   assign p = clamp_deg(p_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= DEG_RESET;
         l_ff <= DEG_RESET;
         c_ff <= DEG_RESET;
         p_ff <= DEG_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SERVERS_PER_LEAF: s_ff <= csr_data;
            CSR_LEAVES_PER_POD:   l_ff <= csr_data;
            CSR_CORES_PER_SPINE:  c_ff <= csr_data;
            CSR_POD_COUNT:        p_ff <= csr_data;
            default:              s_ff <= s_ff;
         endcase
      end
   end

   // three levels: products, pod-wide products, id bases
   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff   <= 13'd16;
         ll_ff    <= 13'd16;
         lc_ff    <= 13'd16;
         pl_ff    <= 13'd16;
         n_srv_ff <= 19'd64;
         pll_ff   <= 19'd64;
         esc_ff   <= 20'd128;
         spine_ff <= 20'd80;
         core_ff  <= 20'd96;
      end else begin
         spp_ff   <= 13'(13'(l) * 13'(s));
         ll_ff    <= 13'(13'(l) * 13'(l));
         lc_ff    <= 13'(13'(l) * 13'(c));
         pl_ff    <= 13'(13'(p) * 13'(l));
         n_srv_ff <= 19'(19'(p) * 19'(spp_ff));
         pll_ff   <= 19'(19'(p) * 19'(ll_ff));
         esc_ff   <= 20'(n_srv_ff) + 20'(pll_ff);
         spine_ff <= 20'(n_srv_ff) + 20'(pl_ff);
         core_ff  <= 20'(n_srv_ff) + 20'({pl_ff, 1'b0});
      end
   end

   always_comb begin
      cfg.s          = s;
      cfg.l          = l;
      cfg.c          = c;
      cfg.spp        = spp_ff;
      cfg.ll         = ll_ff;
      cfg.lc         = lc_ff;
      cfg.n_srv      = n_srv_ff;
      cfg.esc_base   = esc_ff;
      cfg.spine_base = spine_ff;
      cfg.core_base  = core_ff;
   end
endmodule

FILE: design/fat_tree_route_ids.sv
// ----------------------------------------------------------------------------
// fat_tree_route_ids
// Fat-tree path routing: switch node and link ids between two servers.
// ----------------------------------------------------------------------------
// Ten-stage pipeline, one query per cycle while rsp_stall does not back up
// the stages. The first stage registers the query, six stages do restoring
// division (server to pod and leaf, group id to spine and core uplink),
// then one multiply stage, one add stage and a final uplink-multiply and
// select stage that is also the output register. The id bases follow a
// register write through the registered products in ftr_cfg.
module fat_tree_route_ids #(
   parameter int ID_WIDTH = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ftr_pkg::ftr_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ftr_pkg::ftr_rsp_type rsp_data,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [6:0]          csr_data
);
   import ftr_pkg::*;

   localparam int MaskW = (ID_WIDTH < 20) ? ID_WIDTH : 20;
   localparam logic [19:0] IdMask = (20'(1) << MaskW) - 20'd1;
   localparam int Stages = 10;

   typedef struct packed {
      logic [17:0] u;
      logic [17:0] v;
      logic [17:0] ur;
      logic [17:0] vr;
      logic [5:0]  pu;
      logic [5:0]  pv;
      logic [5:0]  lu;
      logic [5:0]  lv;
      logic [15:0] gr;
      logic [5:0]  up;
   } div_type;

   typedef struct packed {
      logic [17:0] u;
      logic [17:0] v;
      logic [5:0]  pu;
      logic [5:0]  pv;
      logic [5:0]  lu;
      logic [5:0]  lv;
      logic [5:0]  spine;
      logic [5:0]  up;
      logic [18:0] pll_u;
      logic [18:0] pll_v;
      logic [12:0] lul_u;
      logic [12:0] lul_v;
      logic [12:0] pl_u;
      logic [12:0] pl_v;
      logic [11:0] root;
   } mul_type;

   typedef struct packed {
      logic [17:0] u;
      logic [17:0] v;
      logic [5:0]  pu;
      logic [5:0]  pv;
      logic [5:0]  lu;
      logic [5:0]  lv;
      logic [5:0]  up;
      logic [19:0] els_u;
      logic [19:0] els_v;
      logic [19:0] leaf_u;
      logic [19:0] leaf_v;
      logic [19:0] snode_u;
      logic [19:0] snode_v;
      logic [12:0] sci_u;
      logic [12:0] sci_v;
      logic [19:0] core;
   } add_type;

   ftr_cfg_type       cfg;
   logic [Stages-1:0] load;
   logic [Stages-1:0] valid;
   div_type           div_ff [0:6];
   div_type           div_in [0:6];
   mul_type           mul_ff, mul_in;
   add_type           add_ff, add_in;
   ftr_rsp_type       out_ff, out_in;

   ftr_cfg cfg_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   ftr_pipe_ctrl #(.STAGES(Stages)) ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .out_stall (rsp_stall),
      .load      (load),
      .valid     (valid)
   );

   always_comb begin
      div_in[0]    = '0;
      div_in[0].u  = req_data.source_server;
      div_in[0].v  = req_data.dest_server;
      div_in[0].ur = req_data.source_server;
      div_in[0].vr = req_data.dest_server;
      div_in[0].gr = req_data.group_id;
   end

   // group id: four stages of gid mod (l*c), then two of that over l
   for (genvar g = 0; g < 6; g++) begin : g_div
      logic [17:0] ur_n, vr_n;
      logic [5:0]  uq_n, vq_n;
      logic [15:0] gr_n;
      logic [5:0]  up_n;

      if (g < 2) begin : g_pod
         ftr_div_step #(.REM_W(18), .DEN_W(13), .Q_W(6), .FIRST(5 - 3 * g), .STEPS(3))
            u_div (.rem_i(div_ff[g].ur), .den_i(cfg.spp), .q_i(div_ff[g].pu),
                   .rem_o(ur_n), .q_o(uq_n));
         ftr_div_step #(.REM_W(18), .DEN_W(13), .Q_W(6), .FIRST(5 - 3 * g), .STEPS(3))
            v_div (.rem_i(div_ff[g].vr), .den_i(cfg.spp), .q_i(div_ff[g].pv),
                   .rem_o(vr_n), .q_o(vq_n));
      end else if (g < 4) begin : g_leaf
         ftr_div_step #(.REM_W(18), .DEN_W(7), .Q_W(6), .FIRST(11 - 3 * g), .STEPS(3))
            u_div (.rem_i(div_ff[g].ur), .den_i(cfg.s), .q_i(div_ff[g].lu),
                   .rem_o(ur_n), .q_o(uq_n));
         ftr_div_step #(.REM_W(18), .DEN_W(7), .Q_W(6), .FIRST(11 - 3 * g), .STEPS(3))
            v_div (.rem_i(div_ff[g].vr), .den_i(cfg.s), .q_i(div_ff[g].lv),
                   .rem_o(vr_n), .q_o(vq_n));
      end else begin : g_idle
         assign ur_n = div_ff[g].ur;
         assign vr_n = div_ff[g].vr;
         assign uq_n = div_ff[g].lu;
         assign vq_n = div_ff[g].lv;
      end

      if (g < 4) begin : g_gmod
         ftr_div_step #(.REM_W(16), .DEN_W(13), .Q_W(16), .FIRST(15 - 4 * g), .STEPS(4))
            g_div (.rem_i(div_ff[g].gr), .den_i(cfg.lc), .q_i(16'd0),
                   .rem_o(gr_n), .q_o());
         assign up_n = div_ff[g].up;
      end else begin : g_gdiv
         ftr_div_step #(.REM_W(16), .DEN_W(7), .Q_W(6), .FIRST(17 - 3 * g), .STEPS(3))
            g_div (.rem_i(div_ff[g].gr), .den_i(cfg.l), .q_i(div_ff[g].up),
                   .rem_o(gr_n), .q_o(up_n));
      end

      always_comb begin
         div_in[g+1]    = div_ff[g];
         div_in[g+1].ur = ur_n;
         div_in[g+1].vr = vr_n;
         div_in[g+1].gr = gr_n;
         div_in[g+1].up = up_n;
         if (g < 2) begin
            div_in[g+1].pu = uq_n;
            div_in[g+1].pv = vq_n;
         end else begin
            div_in[g+1].lu = uq_n;
            div_in[g+1].lv = vq_n;
         end
      end
   end

   for (genvar g = 0; g < 7; g++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (load[g]) begin
            div_ff[g] <= div_in[g];
         end
      end
   end

   // products
   always_comb begin
      mul_in.u     = div_ff[6].u;
      mul_in.v     = div_ff[6].v;
      mul_in.pu    = div_ff[6].pu;
      mul_in.pv    = div_ff[6].pv;
      mul_in.lu    = div_ff[6].lu;
      mul_in.lv    = div_ff[6].lv;
      mul_in.spine = div_ff[6].gr[5:0];
      mul_in.up    = div_ff[6].up;
      mul_in.pll_u = 19'(19'(div_ff[6].pu) * 19'(cfg.ll));
      mul_in.pll_v = 19'(19'(div_ff[6].pv) * 19'(cfg.ll));
      mul_in.lul_u = 13'(13'(div_ff[6].lu) * 13'(cfg.l));
      mul_in.lul_v = 13'(13'(div_ff[6].lv) * 13'(cfg.l));
      mul_in.pl_u  = 13'(13'(div_ff[6].pu) * 13'(cfg.l));
      mul_in.pl_v  = 13'(13'(div_ff[6].pv) * 13'(cfg.l));
      mul_in.root  = 12'(12'(div_ff[6].gr[5:0]) * 12'(cfg.c)) + 12'(div_ff[6].up);
   end

   // id sums
   always_comb begin
      add_in.u       = mul_ff.u;
      add_in.v       = mul_ff.v;
      add_in.pu      = mul_ff.pu;
      add_in.pv      = mul_ff.pv;
      add_in.lu      = mul_ff.lu;
      add_in.lv      = mul_ff.lv;
      add_in.up      = mul_ff.up;
      add_in.els_u   = 20'(cfg.n_srv) + 20'(mul_ff.pll_u) + 20'(mul_ff.lul_u)
                       + 20'(mul_ff.spine);
      add_in.els_v   = 20'(cfg.n_srv) + 20'(mul_ff.pll_v) + 20'(mul_ff.lul_v)
                       + 20'(mul_ff.spine);
      add_in.leaf_u  = 20'(cfg.n_srv) + 20'(mul_ff.pl_u) + 20'(mul_ff.lu);
      add_in.leaf_v  = 20'(cfg.n_srv) + 20'(mul_ff.pl_v) + 20'(mul_ff.lv);
      add_in.snode_u = cfg.spine_base + 20'(mul_ff.pl_u) + 20'(mul_ff.spine);
      add_in.snode_v = cfg.spine_base + 20'(mul_ff.pl_v) + 20'(mul_ff.spine);
      add_in.sci_u   = mul_ff.pl_u + 13'(mul_ff.spine);
      add_in.sci_v   = mul_ff.pl_v + 13'(mul_ff.spine);
      add_in.core    = cfg.core_base + 20'(mul_ff.root);
   end

   // spine-core links and path select
   always_comb begin
      logic [19:0] esc_u, esc_v, uu, vv;
      logic        oor;
      esc_u  = cfg.esc_base + 20'(20'(add_ff.sci_u) * 20'(cfg.c)) + 20'(add_ff.up);
      esc_v  = cfg.esc_base + 20'(20'(add_ff.sci_v) * 20'(cfg.c)) + 20'(add_ff.up);
      uu     = 20'(add_ff.u);
      vv     = 20'(add_ff.v);
      oor    = (19'(add_ff.u) >= cfg.n_srv) || (19'(add_ff.v) >= cfg.n_srv);
      out_in = '0;
      priority if (oor) begin
         out_in.path_kind = KIND_RANGE;
      end else if (add_ff.u == add_ff.v) begin
         out_in.path_kind = KIND_EQUAL;
      end else if (add_ff.pu == add_ff.pv && add_ff.lu == add_ff.lv) begin
         out_in.path_kind  = KIND_SAME_LEAF;
         out_in.hop_edge_0 = uu & IdMask;
         out_in.hop_edge_1 = vv & IdMask;
         out_in.hop_node_0 = add_ff.leaf_u & IdMask;
      end else if (add_ff.pu == add_ff.pv) begin
         out_in.path_kind  = KIND_SAME_POD;
         out_in.hop_edge_0 = uu & IdMask;
         out_in.hop_edge_1 = add_ff.els_u & IdMask;
         out_in.hop_edge_2 = add_ff.els_v & IdMask;
         out_in.hop_edge_3 = vv & IdMask;
         out_in.hop_node_0 = add_ff.leaf_u & IdMask;
         out_in.hop_node_1 = add_ff.snode_u & IdMask;
         out_in.hop_node_2 = add_ff.leaf_v & IdMask;
      end else begin
         out_in.path_kind  = KIND_CROSS_POD;
         out_in.hop_edge_0 = uu & IdMask;
         out_in.hop_edge_1 = add_ff.els_u & IdMask;
         out_in.hop_edge_2 = esc_u & IdMask;
         out_in.hop_edge_3 = esc_v & IdMask;
         out_in.hop_edge_4 = add_ff.els_v & IdMask;
         out_in.hop_edge_5 = vv & IdMask;
         out_in.hop_node_0 = add_ff.leaf_u & IdMask;
         out_in.hop_node_1 = add_ff.snode_u & IdMask;
         out_in.hop_node_2 = add_ff.core & IdMask;
         out_in.hop_node_3 = add_ff.snode_v & IdMask;
         out_in.hop_node_4 = add_ff.leaf_v & IdMask;
      end
   end

   always_ff @(posedge clock) begin
      if (load[7]) begin
         mul_ff <= mul_in;
      end
      if (load[8]) begin
         add_ff <= add_in;
      end
      if (load[9]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = valid[Stages-1];
   assign rsp_data  = out_ff;
endmodule

FILE: design/ftr_checker.sv
// ----------------------------------------------------------------------------
// ftr_checker
// Port-level checks on the routing block's result channel.
// ----------------------------------------------------------------------------
module ftr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ftr_pkg::ftr_rsp_type rsp_data
);
   import ftr_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled transfer dropped");

   a_no_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.path_kind == KIND_EQUAL || rsp_data.path_kind == KIND_RANGE)
      |-> rsp_data.hop_edge_0 == 20'd0 && rsp_data.hop_node_0 == 20'd0
          && rsp_data.hop_edge_5 == 20'd0 && rsp_data.hop_node_4 == 20'd0)
      else $error("flagged result carries path ids");

   a_short_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.path_kind != KIND_CROSS_POD
      |-> rsp_data.hop_edge_4 == 20'd0 && rsp_data.hop_node_3 == 20'd0)
      else $error("short path fills cross-pod slots");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.path_kind <= KIND_RANGE)
      else $error("unknown path kind");
endmodule

bind fat_tree_route_ids ftr_checker checker_inst (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: tb/fat_tree_route_ids_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_tree_route_ids_tb
// Drives route queries through the fat-tree routing block over several tree
// shapes and checks each returned path against a local predictor or given row.
// ----------------------------------------------------------------------------
module fat_tree_route_ids_tb;
   import ftr_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   ftr_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   ftr_rsp_type rsp_data;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [6:0]  csr_data;

   fat_tree_route_ids u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   logic [6:0]  deg_reg [4];
   ftr_rsp_type path_queue [$];
   int          mismatch_count;
   int          cycle_count;
   bit          calm;
   bit          rsp_calm;

   function automatic logic [6:0] deg_eff(input logic [6:0] v);
      if (v == 7'd0) return 7'd1;
      if (v > DEG_MAX) return DEG_MAX;
      return v;
   endfunction

   function automatic ftr_rsp_type route_path(input ftr_req_type q);
      ftr_rsp_type r;
      longint s, l, c, p, u, v, g, nsrv, nleaf, els, esc, spp, sp, up, root;
      longint pu, lu, pv, lv, lfu, lfv;
      s = longint'(deg_eff(deg_reg[CSR_SERVERS_PER_LEAF]));
      l = longint'(deg_eff(deg_reg[CSR_LEAVES_PER_POD]));
      c = longint'(deg_eff(deg_reg[CSR_CORES_PER_SPINE]));
      p = longint'(deg_eff(deg_reg[CSR_POD_COUNT]));
      u = longint'(q.source_server);
      v = longint'(q.dest_server);
      g = longint'(q.group_id);
      nsrv = p * l * s; nleaf = p * l; els = nsrv; esc = nsrv + p * l * l;
      spp = l * s; sp = g % l; up = (g / l) % c; root = sp * c + up;
      r = '0;
      if (u >= nsrv || v >= nsrv) begin
         r.path_kind = KIND_RANGE;
         return r;
      end
      if (u == v) begin
         r.path_kind = KIND_EQUAL;
         return r;
      end
      pu = u / spp; lu = (u % spp) / s; pv = v / spp; lv = (v % spp) / s;
      lfu = nsrv + pu * l + lu; lfv = nsrv + pv * l + lv;
      r.hop_edge_0 = 20'(u);
      r.hop_node_0 = 20'(lfu);
      if (pu == pv && lu == lv) begin
         r.path_kind = KIND_SAME_LEAF;
         r.hop_edge_1 = 20'(v);
      end else if (pu == pv) begin
         r.path_kind = KIND_SAME_POD;
         r.hop_edge_1 = 20'(els + pu * l * l + lu * l + sp);
         r.hop_edge_2 = 20'(els + pu * l * l + lv * l + sp);
         r.hop_edge_3 = 20'(v);
         r.hop_node_1 = 20'(nsrv + nleaf + pu * l + sp);
         r.hop_node_2 = 20'(lfv);
      end else begin
         r.path_kind = KIND_CROSS_POD;
         r.hop_edge_1 = 20'(els + pu * l * l + lu * l + sp);
         r.hop_edge_2 = 20'(esc + (pu * l + sp) * c + up);
         r.hop_edge_3 = 20'(esc + (pv * l + sp) * c + up);
         r.hop_edge_4 = 20'(els + pv * l * l + lv * l + sp);
         r.hop_edge_5 = 20'(v);
         r.hop_node_1 = 20'(nsrv + nleaf + pu * l + sp);
         r.hop_node_2 = 20'(nsrv + 2 * nleaf + root);
         r.hop_node_3 = 20'(nsrv + nleaf + pv * l + sp);
         r.hop_node_4 = 20'(lfv);
      end
      return r;
   endfunction

   // result side: random stall, compare each transfer with oldest expectation
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (path_queue.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            if (rsp_data !== path_queue[0]) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("mismatch exp %h got %h", path_queue[0], rsp_data);
            end
            void'(path_queue.pop_front());
         end
      end
      rsp_stall <= (!rsp_calm && $urandom_range(99) < 26);
      if (cycle_count > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
      csr_write_en <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      deg_reg[idx] = val;
      @(posedge clock);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (path_queue.size() != 0) @(posedge clock);
      repeat (14) @(posedge clock);
   endtask

   // one transfer; the expected row is filled by the predictor unless given
   task automatic send_query(input ftr_req_type q, input bit has_exp,
                             input ftr_rsp_type exp_r);
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1; req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      path_queue = {path_queue, (has_exp ? exp_r : route_path(q))};
   endtask

   typedef struct {
      ftr_req_type q;
      bit          has_exp;
      ftr_rsp_type r;
   } query_row_type;

   function automatic query_row_type row(input int a, input int b, input int g,
                                         input bit he, input logic [2:0] kind);
      query_row_type w;
      w.q = '{a[17:0], b[17:0], g[15:0]};
      w.has_exp = he; w.r = '0; w.r.path_kind = kind;
      return w;
   endfunction

   task automatic random_phase(input int n);
      ftr_req_type q;
      int nsrv;
      nsrv = int'(deg_eff(deg_reg[CSR_SERVERS_PER_LEAF]))
             * int'(deg_eff(deg_reg[CSR_LEAVES_PER_POD]))
             * int'(deg_eff(deg_reg[CSR_POD_COUNT]));
      repeat (n) begin
         q.group_id = 16'($urandom());
         case ($urandom_range(9))
            0: begin
               q.source_server = 18'($urandom());
               q.dest_server = 18'($urandom());
            end
            1: begin
               q.source_server = 18'($urandom_range(nsrv - 1));
               q.dest_server = q.source_server;
            end
            2: begin
               q.source_server = 18'($urandom_range(nsrv - 1));
               q.dest_server = 18'(nsrv + int'($urandom_range(3)));
            end
            3: begin
               q.source_server = 18'($urandom_range(nsrv - 1));
               q.dest_server = 18'((int'(q.source_server) ^ 1) % nsrv);
            end
            default: begin
               q.source_server = 18'($urandom_range(nsrv - 1));
               q.dest_server = 18'($urandom_range(nsrv - 1));
            end
         endcase
         send_query(q, 1'b0, '0);
      end
   endtask

   query_row_type rows [$];
   ftr_rsp_type   none;

   initial begin
      reset = 1'b1; req_valid = 1'b0; req_data = '0; rsp_stall = 1'b0;
      csr_write_en = 1'b0; csr_index = '0; csr_data = '0;
      mismatch_count = 0; cycle_count = 0; calm = 1'b0; rsp_calm = 1'b0;
      none = '0;
      for (int i = 0; i < 4; i++) deg_reg[i] = DEG_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset shape: 64 servers
      rows = {rows, row(0, 0, 0, 1'b1, KIND_EQUAL)};
      rows = {rows, row(64, 1, 0, 1'b1, KIND_RANGE)};
      rows = {rows, row(262143, 262143, 65535, 1'b1, KIND_RANGE)};
      rows = {rows, row(3, 64, 5, 1'b1, KIND_RANGE)};
      rows = {rows, row(0, 1, 0, 1'b0, KIND_SAME_LEAF)};
      rows = {rows, row(0, 5, 65535, 1'b0, KIND_SAME_LEAF)};
      rows = {rows, row(0, 63, 65535, 1'b0, KIND_SAME_LEAF)};
      rows = {rows, row(63, 0, 7, 1'b0, KIND_SAME_LEAF)};
      rows = {rows, row(17, 34, 12345, 1'b0, KIND_SAME_LEAF)};
      rows = {rows, row(20, 20, 3, 1'b1, KIND_EQUAL)};
      foreach (rows[i]) send_query(rows[i].q, rows[i].has_exp, rows[i].r);
      drain_pipe();
      // smallest tree: one server, zero registers clamp to one
      for (int i = 0; i < 4; i++) write_reg(i[1:0], 7'd0);
      rows = {};
      rows = {rows, row(0, 0, 65535, 1'b1, KIND_EQUAL)};
      rows = {rows, row(0, 1, 0, 1'b1, KIND_RANGE)};
      foreach (rows[i]) send_query(rows[i].q, rows[i].has_exp, rows[i].r);
      drain_pipe();
      // largest tree, values above the maximum clamp
      write_reg(CSR_SERVERS_PER_LEAF, 7'd127);
      write_reg(CSR_LEAVES_PER_POD, 7'd64);
      write_reg(CSR_CORES_PER_SPINE, 7'd100);
      write_reg(CSR_POD_COUNT, 7'd64);
      send_query('{18'd0, 18'd262143, 16'd65535}, 1'b0, none);
      send_query('{18'd262143, 18'd1, 16'd65535}, 1'b0, none);
      send_query('{18'd4096, 18'd8191, 16'd4095}, 1'b0, none);
      calm = 1'b1; rsp_calm = 1'b1;
      random_phase(150);
      calm = 1'b0; rsp_calm = 1'b0;
      random_phase(100);
      drain_pipe();
      for (int k = 0; k < 8; k++) begin
         for (int i = 0; i < 4; i++) write_reg(i[1:0], 7'($urandom_range(1, 8)));
         random_phase(150);
         drain_pipe();
      end
      write_reg(CSR_SERVERS_PER_LEAF, 7'd2);
      write_reg(CSR_LEAVES_PER_POD, 7'd64);
      write_reg(CSR_CORES_PER_SPINE, 7'd64);
      write_reg(CSR_POD_COUNT, 7'd3);
      random_phase(150);
      drain_pipe();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/ftr_pkg.sv
design/ftr_div_step.sv
design/ftr_pipe_ctrl.sv
design/ftr_cfg.sv
design/fat_tree_route_ids.sv
design/ftr_checker.sv
tb/fat_tree_route_ids_tb.sv
